[design/rdx_pkg.sv]
package rdx_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int MAX_DIGITS_DEF  = 31;
    localparam int RADIX_WIDTH     = 6;
    localparam int SYMBOL_WIDTH    = 7;

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 6'd37;

    localparam logic [SYMBOL_WIDTH-1:0] SYM_DIGIT0 = 7'h30;
    localparam logic [SYMBOL_WIDTH-1:0] SYM_ALPHA0 = 7'h41;
    localparam logic [SYMBOL_WIDTH-1:0] SYM_EXTRA  = 7'h24;
    localparam logic [SYMBOL_WIDTH-1:0] SYM_ERROR  = 7'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_READ,
        ST_EMIT,
        ST_ERR
    } rdx_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic start_read;
        logic rd;
        logic emit;
        logic emit_err;
    } rdx_cmd_t;

    typedef struct packed {
        logic in_bad;
        logic step_last;
        logic quo_zero;
        logic ptr_zero;
        logic out_free;
    } rdx_sts_t;

    function automatic logic [SYMBOL_WIDTH-1:0] digit_symbol(input logic [RADIX_WIDTH-1:0] d);
        logic [SYMBOL_WIDTH-1:0] s;
        if (d < 6'd10)
        begin
            s = SYM_DIGIT0 + {1'b0, d};
        end
        else if (d < 6'd36)
        begin
            s = SYM_ALPHA0 + {1'b0, d - 6'd10};
        end
        else
        begin
            s = SYM_EXTRA;
        end
        return s;
    endfunction

endpackage

[design/rdx_ifs.sv]
interface rdx_num_if #(
    parameter int VALUE_WIDTH = rdx_pkg::VALUE_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic [VALUE_WIDTH-1:0]             value;
    logic [rdx_pkg::RADIX_WIDTH-1:0]    radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rdx_sym_if;
    logic                               valid;
    logic                               ready;
    logic [rdx_pkg::SYMBOL_WIDTH-1:0]   symbol;
    logic                               last;
    logic                               bad_radix;

    modport source (output valid, output symbol, output last, output bad_radix, input ready);
    modport sink   (input valid, input symbol, input last, input bad_radix, output ready);
endinterface

[design/integer_to_radix_digits_top.sv]
// Converts a non-negative VALUE_WIDTH-bit integer to its digits in a base from 2 to 37 and
// sends them most significant first, one ASCII symbol per transaction on sym, with last set on
// the final one (digits 0-9 as '0'-'9', 10-35 as 'A'-'Z', 36 as '$'; zero gives a single '0').
// A base outside 2..37 gives one transaction with bad_radix set and symbol 0. Only the low
// MAX_DIGITS digits are kept if a number has more. One conversion runs at a time: each digit
// takes a pass of the bit-serial restoring divider, then each symbol is read out through the
// registered-read digit buffer into the output register. A new transaction on num is taken
// once the last symbol of the previous one is in the output register.
module integer_to_radix_digits_top #(
    parameter int VALUE_WIDTH = rdx_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = rdx_pkg::MAX_DIGITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    rdx_num_if.sink     num,
    rdx_sym_if.source   sym
);
    import rdx_pkg::*;

    rdx_cmd_t cmd;
    rdx_sts_t sts;

    rdx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num.valid),
        .num_ready (num.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rdx_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .num_value     (num.value),
        .num_radix     (num.radix),
        .sym_valid     (sym.valid),
        .sym_ready     (sym.ready),
        .sym_symbol    (sym.symbol),
        .sym_last      (sym.last),
        .sym_bad_radix (sym.bad_radix)
    );

endmodule

[design/rdx_ram.sv]
module rdx_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/rdx_datapath.sv]
module rdx_datapath #(
    parameter int VALUE_WIDTH = rdx_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = rdx_pkg::MAX_DIGITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rdx_pkg::rdx_cmd_t                  cmd,
    output rdx_pkg::rdx_sts_t                  sts,
    input  logic [VALUE_WIDTH-1:0]             num_value,
    input  logic [rdx_pkg::RADIX_WIDTH-1:0]    num_radix,
    output logic                               sym_valid,
    input  logic                               sym_ready,
    output logic [rdx_pkg::SYMBOL_WIDTH-1:0]   sym_symbol,
    output logic                               sym_last,
    output logic                               sym_bad_radix
);
    import rdx_pkg::*;

    localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    logic [VALUE_WIDTH-1:0]  quo_reg, quo_next;
    logic [RADIX_WIDTH-1:0]  rem_reg, rem_next;
    logic [RADIX_WIDTH-1:0]  rad_reg;
    logic [BW-1:0]           bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]           dig_cnt_reg, dig_cnt_next;
    logic [AW-1:0]           ptr_reg, ptr_next;

    logic                    out_valid_reg, out_valid_next;
    logic [SYMBOL_WIDTH-1:0] out_symbol_reg, out_symbol_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_bad_reg, out_bad_next;

    logic [RADIX_WIDTH:0]    rem_sh;
    logic                    ge;
    logic [RADIX_WIDTH-1:0]  rem_sub;
    logic                    room;
    logic [RADIX_WIDTH-1:0]  rd_data;

    // one restoring division step: shift in the next dividend bit, try subtract
    assign rem_sh  = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign ge      = rem_sh >= {1'b0, rad_reg};
    assign rem_sub = RADIX_WIDTH'(rem_sh - {1'b0, rad_reg});
    assign room    = dig_cnt_reg < CW'(MAX_DIGITS);

    // digit i (least significant first) lands at address i; higher digits past the buffer drop
    rdx_ram #(
        .WIDTH (RADIX_WIDTH),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .clk     (clk),
        .wr_en   (cmd.store && room),
        .wr_addr (dig_cnt_reg[AW-1:0]),
        .wr_data (rem_reg),
        .rd_en   (cmd.rd),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        bit_cnt_next    = bit_cnt_reg;
        dig_cnt_next    = dig_cnt_reg;
        ptr_next        = ptr_reg;
        out_valid_next  = out_valid_reg;
        out_symbol_next = out_symbol_reg;
        out_last_next   = out_last_reg;
        out_bad_next    = out_bad_reg;

        if (out_valid_reg && sym_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            quo_next     = num_value;
            rem_next     = '0;
            bit_cnt_next = '0;
            dig_cnt_next = '0;
        end

        if (cmd.step)
        begin
            quo_next     = {quo_reg[VALUE_WIDTH-2:0], ge};
            rem_next     = ge ? rem_sub : rem_sh[RADIX_WIDTH-1:0];
            bit_cnt_next = bit_cnt_reg + BW'(1);
        end

        if (cmd.store)
        begin
            rem_next     = '0;
            bit_cnt_next = '0;
            if (room)
            begin
                dig_cnt_next = dig_cnt_reg + CW'(1);
            end
        end

        if (cmd.start_read)
        begin
            ptr_next = room ? dig_cnt_reg[AW-1:0] : AW'(MAX_DIGITS - 1);
        end

        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_symbol_next = digit_symbol(rd_data);
            out_last_next   = (ptr_reg == '0);
            out_bad_next    = 1'b0;
            ptr_next        = ptr_reg - AW'(1);
        end

        if (cmd.emit_err)
        begin
            out_valid_next  = 1'b1;
            out_symbol_next = SYM_ERROR;
            out_last_next   = 1'b1;
            out_bad_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        out_symbol_reg <= out_symbol_next;
        out_last_reg   <= out_last_next;
        out_bad_reg    <= out_bad_next;
        if (cmd.load)
        begin
            rad_reg <= num_radix;
        end
    end

    always_comb
    begin
        sts.in_bad    = (num_radix < RADIX_MIN) || (num_radix > RADIX_MAX);
        sts.step_last = (bit_cnt_reg == BW'(VALUE_WIDTH - 1));
        sts.quo_zero  = (quo_reg == '0);
        sts.ptr_zero  = (ptr_reg == '0);
        sts.out_free  = !out_valid_reg || sym_ready;
    end

    assign sym_valid     = out_valid_reg;
    assign sym_symbol    = out_symbol_reg;
    assign sym_last      = out_last_reg;
    assign sym_bad_radix = out_bad_reg;

endmodule

[design/rdx_ctrl.sv]
module rdx_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              num_valid,
    output logic              num_ready,
    input  rdx_pkg::rdx_sts_t sts,
    output rdx_pkg::rdx_cmd_t cmd
);
    import rdx_pkg::*;

    rdx_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        num_ready  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                num_ready = 1'b1;
                if (num_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_bad ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                // remainder is the next digit; quotient feeds the next pass
                cmd.store = 1'b1;
                if (sts.quo_zero)
                begin
                    cmd.start_read = 1'b1;
                    state_next     = ST_READ;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.ptr_zero ? ST_IDLE : ST_READ;
                end
            end
            ST_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sim/tb.sv]
module tb;
    import rdx_pkg::*;

    localparam int VW          = VALUE_WIDTH_DEF;
    localparam int MD          = MAX_DIGITS_DEF;
    localparam int IDLE_LIMIT  = 6000;
    localparam int ITEM_CYCLES = 1100;

    localparam logic [VW-1:0] VALUE_MAX = {VW{1'b1}};

    typedef struct packed {
        logic [SYMBOL_WIDTH-1:0] symbol;
        logic                    last;
        logic                    bad_radix;
    } digit_sym_t;

    logic clk = 1'b0;
    logic rst_n;

    rdx_num_if #(.VALUE_WIDTH(VW)) num_ch ();
    rdx_sym_if                     sym_ch ();

    integer_to_radix_digits_top #(
        .VALUE_WIDTH(VW),
        .MAX_DIGITS (MD)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .num  (num_ch),
        .sym  (sym_ch)
    );

    digit_sym_t  expected_syms[$];
    digit_sym_t  oldest_sym;
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;
    bit          no_gaps = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [SYMBOL_WIDTH-1:0] ascii_of_digit(input int unsigned d);
        if (d < 10)
        begin
            return SYM_DIGIT0 + SYMBOL_WIDTH'(d);
        end
        else if (d < 36)
        begin
            return SYM_ALPHA0 + SYMBOL_WIDTH'(d - 10);
        end
        return SYM_EXTRA;
    endfunction

    // queue up the symbols one conversion should produce
    function automatic void predict_digits(input logic [VW-1:0] value,
                                           input logic [RADIX_WIDTH-1:0] radix);
        int unsigned digs[64];
        longint unsigned v;
        int n;
        int cnt;
        digit_sym_t s;
        v = value;
        n = 0;
        if (radix < RADIX_MIN || radix > RADIX_MAX)
        begin
            s.symbol    = SYM_ERROR;
            s.last      = 1'b1;
            s.bad_radix = 1'b1;
            expected_syms.push_back(s);
            return;
        end
        do
        begin
            digs[n] = int'(v % radix);
            v       = v / radix;
            n++;
        end
        while (v != 0 && n < 64);
        cnt = (n > MD) ? MD : n;
        for (int k = 0; k < cnt; k++)
        begin
            s.symbol    = ascii_of_digit(digs[cnt - 1 - k]);
            s.last      = (k == cnt - 1);
            s.bad_radix = 1'b0;
            expected_syms.push_back(s);
        end
    endfunction

    function automatic int unsigned pick_wait();
        if (no_gaps || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // one transaction on num, driven on a falling edge after an optional random gap
    task automatic send_number(input logic [VW-1:0] value, input logic [RADIX_WIDTH-1:0] radix);
        int unsigned gap;
        gap = pick_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            num_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        num_ch.valid = 1'b1;
        num_ch.value = value;
        num_ch.radix = radix;
        do
        begin
            @(posedge clk);
        end
        while (!num_ch.ready);
        predict_digits(value, radix);
    endtask

    task automatic wait_for_symbols();
        @(negedge clk);
        num_ch.valid = 1'b0;
        while (expected_syms.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [RADIX_WIDTH-1:0] rand_radix();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            return RADIX_WIDTH'($urandom_range(0, 1));
        end
        else if (pick == 1)
        begin
            return RADIX_WIDTH'($urandom_range(38, 63));
        end
        else if (pick == 2)
        begin
            return RADIX_WIDTH'($urandom_range(0, 2) + 35);
        end
        else if (pick == 3)
        begin
            return RADIX_MIN;
        end
        return RADIX_WIDTH'($urandom_range(2, 37));
    endfunction

    function automatic logic [VW-1:0] rand_value(input logic [RADIX_WIDTH-1:0] radix);
        longint unsigned p;
        int unsigned k;
        int unsigned w;
        case ($urandom_range(0, 3))
            0: return VW'($urandom());
            1:
            begin
                w = $urandom_range(1, VW);
                return VW'($urandom()) & VW'((64'd1 << w) - 1);
            end
            2:
            begin
                // powers of the base and one below them hit digit-count boundaries
                p = 1;
                k = $urandom_range(1, VW);
                if (radix >= RADIX_MIN)
                begin
                    repeat (k)
                    begin
                        if (p * radix <= longint'(VALUE_MAX))
                        begin
                            p = p * radix;
                        end
                    end
                end
                return VW'(($urandom_range(0, 1) == 1) ? p : p - 1);
            end
            default: return VW'($urandom_range(0, 50));
        endcase
    endfunction

    task automatic test_edge_values();
        send_number('0, RADIX_MIN);
        send_number('0, 6'd10);
        send_number('0, RADIX_MAX);
        send_number(VALUE_MAX, RADIX_MIN);
        send_number(VALUE_MAX, 6'd10);
        send_number(VALUE_MAX, 6'd16);
        send_number(VALUE_MAX, 6'd36);
        send_number(VALUE_MAX, RADIX_MAX);
        send_number(VW'(1), RADIX_MIN);
        send_number(VW'(1), RADIX_MAX);
    endtask

    task automatic test_symbol_map();
        send_number(VW'(9), 6'd10);
        send_number(VW'(10), 6'd11);
        send_number(VW'(35), 6'd36);
        send_number(VW'(36), RADIX_MAX);
        send_number(VW'(37), RADIX_MAX);
        // digits 36, 10, 9 in base 37
        send_number(VW'(49663), RADIX_MAX);
    endtask

    task automatic test_bad_radix();
        send_number(VW'(5), 6'd0);
        send_number(VALUE_MAX, 6'd1);
        send_number('0, 6'd38);
        send_number(VW'(123), 6'd63);
        send_number(VALUE_MAX, 6'd63);
    endtask

    task automatic test_random_mix(input int unsigned count);
        logic [RADIX_WIDTH-1:0] r;
        repeat (count)
        begin
            r = rand_radix();
            send_number(rand_value(r), r);
        end
    endtask

    task automatic test_back_to_back(input int unsigned count);
        no_gaps = 1'b1;
        test_random_mix(count);
        no_gaps = 1'b0;
    endtask

    task automatic test_after_drain(input int unsigned count);
        wait_for_symbols();
        test_random_mix(count);
    endtask

    // sink side: random stalls on sym
    initial
    begin : sym_sink
        int unsigned stall;
        sym_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = pick_wait();
            if (stall > 0)
            begin
                sym_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            sym_ch.ready = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!sym_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sym_ch.valid && sym_ch.ready)
        begin
            if (expected_syms.size() == 0)
            begin
                report_mismatch("symbol with nothing expected", sym_ch.symbol, 0);
            end
            else
            begin
                oldest_sym = expected_syms.pop_front();
                if (sym_ch.symbol !== oldest_sym.symbol)
                begin
                    report_mismatch("symbol", sym_ch.symbol, oldest_sym.symbol);
                end
                if (sym_ch.last !== oldest_sym.last)
                begin
                    report_mismatch("last", sym_ch.last, oldest_sym.last);
                end
                if (sym_ch.bad_radix !== oldest_sym.bad_radix)
                begin
                    report_mismatch("bad_radix", sym_ch.bad_radix, oldest_sym.bad_radix);
                end
            end
        end
    end

    // watchdog: a long stretch with no transaction on either side means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((num_ch.valid && num_ch.ready) || (sym_ch.valid && sym_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("** integer_to_radix_digits_top: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        num_ch.valid = 1'b0;
        num_ch.value = '0;
        num_ch.radix = '0;
        rst_n        = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edge_values();
        test_symbol_map();
        test_bad_radix();
        test_random_mix(300);
        test_back_to_back(100);
        test_after_drain(45);

        wait_for_symbols();
        repeat (ITEM_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** integer_to_radix_digits_top: PASSED **");
        end
        else
        begin
            $display("** integer_to_radix_digits_top: FAILED **");
        end
        $finish;
    end
endmodule
